@@ rtl/brle_pkg.sv @@
// package for the byte run-length encoder
// holds the result record type and fixed constants; no dependencies
`default_nettype none

package brle_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam logic [BYTE_W-1:0] MAX_COUNT = 8'd255;

   // result queue depth, two requests' worth of results
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              is_literal;
      logic              end_of_stream;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/byte_run_length_encoder.sv @@
// top level of the byte run-length encoder
// depends on brle_pkg for the result record and constants
`default_nettype none

// Byte run-length encoder. Each request carries one byte and a last-byte
// flag. The first byte of every run goes out as a literal; further equal
// bytes are counted, and when the run ends the count goes out as a count
// result (2..255), or as a second literal when only one copy followed.
// The last byte flushes any pending count and marks the final result of
// that request with end_of_stream, then the encoder returns to idle.
// A request is decoded in the cycle it is accepted and yields zero, one or
// two results, which are written into a four-entry result queue; the
// response channel reads one result per cycle from the queue head while rsp_ready is high.
// req_ready is high while at least two queue slots are free, so a request
// can be taken every cycle as long as the results drain; a stream that
// makes two results per request fills the queue faster than the single
// response port drains it, so req_ready holds its requests back.
module byte_run_length_encoder
   import brle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_last_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_code_byte,
   output logic                   rsp_is_literal,
   output logic                   rsp_end_of_stream
);

   // run state
   logic              run_active_ff, run_active_in;
   logic [BYTE_W-1:0] run_value_ff, run_value_in;
   logic [BYTE_W-1:0] repeat_count_ff, repeat_count_in;

   // result queue
   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   logic              req_fire;
   logic              rsp_fire;
   logic              same_run;
   logic [BYTE_W-1:0] count_inc;
   logic [1:0]        push_cnt;
   result_type        res0, res1;
   result_type        flush_res;
   logic              flush_valid;
   logic [QPTR_W-1:0] wr_ptr_next;

   // room for the worst case of two results
   assign req_ready = (fill_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_fire  = rsp_valid & rsp_ready;

   assign rsp_code_byte     = queue_ff[rd_ptr_ff].code_byte;
   assign rsp_is_literal    = queue_ff[rd_ptr_ff].is_literal;
   assign rsp_end_of_stream = queue_ff[rd_ptr_ff].end_of_stream;

   // byte extends the open run unless the count is saturated
   assign same_run  = run_active_ff && (req_data_byte == run_value_ff)
                      && (repeat_count_ff != MAX_COUNT);
   assign count_inc = repeat_count_ff + BYTE_W'(1);

   // decode one request into up to two results and the next run state
   always_comb begin
      res0            = '0;
      res1            = '0;
      push_cnt        = 2'd0;
      flush_res       = '0;
      flush_valid     = 1'b0;
      run_active_in   = run_active_ff;
      run_value_in    = run_value_ff;
      repeat_count_in = repeat_count_ff;

      if (same_run) begin
         repeat_count_in = count_inc;
         // last byte: flush the grown count, it is at least one
         if (req_last_byte) begin
            res0.is_literal    = (count_inc == BYTE_W'(1));
            res0.code_byte     = res0.is_literal ? run_value_ff : count_inc;
            res0.end_of_stream = 1'b1;
            push_cnt           = 2'd1;
         end
      end else begin
         // pending count of the run that closes here
         flush_valid          = run_active_ff && (repeat_count_ff != '0);
         flush_res.is_literal = (repeat_count_ff == BYTE_W'(1));
         flush_res.code_byte  = flush_res.is_literal ? run_value_ff : repeat_count_ff;
         if (flush_valid) begin
            res0               = flush_res;
            res1.code_byte     = req_data_byte;
            res1.is_literal    = 1'b1;
            res1.end_of_stream = req_last_byte;
            push_cnt           = 2'd2;
         end else begin
            res0.code_byte     = req_data_byte;
            res0.is_literal    = 1'b1;
            res0.end_of_stream = req_last_byte;
            push_cnt           = 2'd1;
         end
         run_active_in   = 1'b1;
         run_value_in    = req_data_byte;
         repeat_count_in = '0;
      end

      // end of stream returns to idle
      if (req_last_byte) begin
         run_active_in   = 1'b0;
         run_value_in    = '0;
         repeat_count_in = '0;
      end
   end

   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
         fill_in   = fill_in + QCNT_W'(push_cnt);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
         fill_in   = fill_in - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff   <= 1'b0;
         run_value_ff    <= '0;
         repeat_count_ff <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fill_ff         <= '0;
      end else begin
         if (req_fire) begin
            run_active_ff   <= run_active_in;
            run_value_ff    <= run_value_in;
            repeat_count_ff <= repeat_count_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (push_cnt != 2'd0) begin
            queue_ff[wr_ptr_ff] <= res0;
         end
         if (push_cnt == 2'd2) begin
            queue_ff[wr_ptr_next] <= res1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/brle_checker.sv @@
// port-level checker for the byte run-length encoder
// bound to byte_run_length_encoder; uses brle_pkg for the byte width
`default_nettype none

module brle_port_checks
   import brle_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [BYTE_W-1:0] req_data_byte,
   input wire logic              req_last_byte,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_code_byte,
   input wire logic              rsp_is_literal,
   input wire logic              rsp_end_of_stream
);

   // a count result always carries at least two
   a_count_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_literal) |-> (rsp_code_byte != 8'd0 && rsp_code_byte != 8'd1))
      else $error("count result below two");

   // nothing to send right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a result only shows up after an accepted request
   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("response without request");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_code_byte) && $stable(rsp_is_literal)
          && $stable(rsp_end_of_stream)))
      else $error("stalled response changed");

endmodule

bind byte_run_length_encoder brle_port_checks u_brle_port_checks (.*);

`default_nettype wire

@@ verif/brle_checker.sv @@
// checker for the byte run-length encoder: watches both channels, predicts, compares
// depends on brle_pkg for the result record and the count limit
`timescale 1ns / 1ps

module brle_checker
   import brle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_last_byte,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [BYTE_W-1:0] rsp_code_byte,
   input  wire logic              rsp_is_literal,
   input  wire logic              rsp_end_of_stream,
   output int                     fail_count,
   output int                     pending_results
);

   // encoder state as predicted
   logic              run_open;
   logic [BYTE_W-1:0] run_byte;
   logic [BYTE_W-1:0] run_copies;

   result_type expected_codes[$];
   result_type step_codes[2];
   int         step_total;
   int         mismatch_total;

   assign fail_count = mismatch_total;

   initial begin
      mismatch_total  = 0;
      pending_results = 0;
      run_open        = 1'b0;
      run_byte        = '0;
      run_copies      = '0;
   end

   task add_code(input logic [BYTE_W-1:0] code, input logic literal);
      result_type r;
      r.code_byte     = code;
      r.is_literal    = literal;
      r.end_of_stream = 1'b0;
      step_codes[step_total] = r;
      step_total = step_total + 1;
   endtask

   // pending copies: none, one (second literal) or a count
   task flush_copies();
      if (run_copies == 1)
         add_code(run_byte, 1'b1);
      else if (run_copies >= 2)
         add_code(run_copies, 1'b0);
      run_copies = '0;
   endtask

   task predict_request(input logic [BYTE_W-1:0] din, input logic last);
      result_type r;
      step_total = 0;
      if (run_open && din == run_byte && run_copies < MAX_COUNT) begin
         run_copies = run_copies + 1'b1;
      end else begin
         if (run_open)
            flush_copies();
         add_code(din, 1'b1);
         run_open   = 1'b1;
         run_byte   = din;
         run_copies = '0;
      end
      if (last) begin
         flush_copies();
         r = step_codes[step_total-1];
         r.end_of_stream = 1'b1;
         step_codes[step_total-1] = r;
         run_open   = 1'b0;
         run_byte   = '0;
         run_copies = '0;
      end
      for (int i = 0; i < step_total; i++)
         expected_codes.push_back(step_codes[i]);
   endtask

   task check_result();
      result_type want;
      if (expected_codes.size() == 0) begin
         mismatch_total = mismatch_total + 1;
         $display("%0t: unexpected result code_byte %0d is_literal %0b end_of_stream %0b",
                  $time, rsp_code_byte, rsp_is_literal, rsp_end_of_stream);
      end else begin
         want = expected_codes.pop_front();
         if (rsp_code_byte !== want.code_byte) begin
            mismatch_total = mismatch_total + 1;
            $display("%0t: code_byte expected %0d actual %0d",
                     $time, want.code_byte, rsp_code_byte);
         end
         if (rsp_is_literal !== want.is_literal) begin
            mismatch_total = mismatch_total + 1;
            $display("%0t: is_literal expected %0b actual %0b",
                     $time, want.is_literal, rsp_is_literal);
         end
         if (rsp_end_of_stream !== want.end_of_stream) begin
            mismatch_total = mismatch_total + 1;
            $display("%0t: end_of_stream expected %0b actual %0b",
                     $time, want.end_of_stream, rsp_end_of_stream);
         end
      end
   endtask

   // results are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         run_open   = 1'b0;
         run_byte   = '0;
         run_copies = '0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            check_result();
         if (req_valid === 1'b1 && req_ready === 1'b1)
            predict_request(req_data_byte, req_last_byte);
      end
      pending_results <= expected_codes.size();
   end

endmodule

@@ verif/byte_run_length_encoder_tb.sv @@
// testbench top for the byte run-length encoder: stimulus, response stalls, verdict
// depends on brle_pkg, byte_run_length_encoder and brle_checker
`timescale 1ns / 1ps

module byte_run_length_encoder_tb
   import brle_pkg::*;
();

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 30;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic [BYTE_W-1:0] rsp_code_byte;
   logic              rsp_is_literal;
   logic              rsp_end_of_stream;

   int   fail_count;
   int   pending_results;
   int   cycle_count   = 0;
   int   random_sent   = 0;
   logic idle_enable   = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_run_length_encoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_is_literal    (rsp_is_literal),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   brle_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_is_literal    (rsp_is_literal),
      .rsp_end_of_stream (rsp_end_of_stream),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // response side stalls at random, independent of rsp_valid
   always @(posedge clock) begin
      if (idle_enable && $urandom_range(99) < IDLE_PCT)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= 1'b1;
   end

   // watchdog: a hung encoder or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // present a request and hold it until accepted; called just after the clock rises
   task automatic send_request(input logic [BYTE_W-1:0] din, input logic last);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= din;
      req_last_byte <= last;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
   endtask

   // sender pauses until every predicted result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      // first edge lets the checker count the request just accepted
      do
         @(posedge clock);
      while (pending_results != 0);
   endtask

   // random byte with extra weight on the extremes
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   // well-formed stream: a few runs, some long enough to cross the count limit
   task automatic send_run_stream();
      int                n_runs;
      int                run_len;
      int                sel;
      logic [BYTE_W-1:0] value;
      n_runs = $urandom_range(6, 1);
      value  = pick_byte();
      for (int r = 0; r < n_runs; r++) begin
         // sometimes repeat the previous run's byte so runs merge
         if ($urandom_range(3) != 0)
            value = pick_byte();
         sel = $urandom_range(99);
         if (sel < 60)
            run_len = $urandom_range(3, 1);
         else if (sel < 92)
            run_len = $urandom_range(12, 4);
         else
            run_len = $urandom_range(258, 253);   // around count 255 and overflow
         for (int i = 0; i < run_len; i++) begin
            send_request(value, (r == n_runs - 1) && (i == run_len - 1));
            random_sent++;
         end
      end
   endtask

   // noise: bytes from a tiny set with the last flag thrown in anywhere
   task automatic send_noise_stream();
      int                n_items;
      logic [BYTE_W-1:0] pair_a;
      logic [BYTE_W-1:0] pair_b;
      n_items = $urandom_range(12, 1);
      pair_a  = pick_byte();
      pair_b  = pick_byte();
      for (int i = 0; i < n_items; i++) begin
         send_request($urandom_range(1) ? pair_a : pair_b,
                      (i == n_items - 1) || ($urandom_range(3) == 0));
         random_sent++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle encoder with the reset run byte, then a lone last byte at each extreme
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b1);
      // single repeated copy flushed by the last byte as a second literal
      send_request(8'h12, 1'b0);
      send_request(8'h12, 1'b1);
      // count of two flushed by a different byte
      send_request(8'h34, 1'b0);
      send_request(8'h34, 1'b0);
      send_request(8'h34, 1'b0);
      send_request(8'h56, 1'b0);
      // one copy flushed by a different byte
      send_request(8'h56, 1'b0);
      send_request(8'h00, 1'b0);
      // count flushed by the last byte itself
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b1);
      // new byte with last set and nothing pending
      send_request(8'hAA, 1'b0);
      send_request(8'h55, 1'b1);
      // pending count flushed, then the new last byte as a literal
      send_request(8'h77, 1'b0);
      send_request(8'h77, 1'b0);
      send_request(8'h77, 1'b0);
      send_request(8'h01, 1'b1);
      // encoder back at idle: same byte again opens a fresh run
      send_request(8'h01, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'hFE, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h7F, 1'b1);
      wait_drain();

      while (random_sent < RANDOM_ITEMS) begin
         // a long stretch with both sides running flat out
         idle_enable <= !(random_sent >= 350 && random_sent < 600);
         if ($urandom_range(99) < 85)
            send_run_stream();
         else
            send_noise_stream();
         if ($urandom_range(9) == 0)
            wait_drain();
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
rtl/brle_pkg.sv
rtl/byte_run_length_encoder.sv
rtl/brle_checker.sv
verif/brle_checker.sv
verif/byte_run_length_encoder_tb.sv
